FILE: sv/sadpc_pkg.sv
// Shared types, codes and constants for the streamed audio/data port controller.
package sadpc_pkg;

   typedef logic signed [15:0] sample_type;

   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_TICK   = 2'd2,
      OP_REPORT = 2'd3
   } op_type;

   // register window indexes
   localparam logic [2:0] REG_STATUS   = 3'd0;
   localparam logic [2:0] REG_DATA     = 3'd1;
   localparam logic [2:0] REG_SEEK0    = 3'd0;
   localparam logic [2:0] REG_SEEK1    = 3'd1;
   localparam logic [2:0] REG_SEEK2    = 3'd2;
   localparam logic [2:0] REG_SEEK3    = 3'd3;
   localparam logic [2:0] REG_TRACK_LO = 3'd4;
   localparam logic [2:0] REG_TRACK_HI = 3'd5;
   localparam logic [2:0] REG_VOLUME   = 3'd6;
   localparam logic [2:0] REG_CONTROL  = 3'd7;

   localparam logic [2:0]  REVISION      = 3'd2;
   localparam logic [31:0] HDR_MAGIC     = 32'h4d53_5531;
   localparam logic [31:0] TRACK_START   = 32'd8;
   localparam logic [31:0] SAMPLE_BYTES  = 32'd4;
   localparam logic [15:0] NO_RESUME     = 16'hffff;
   localparam logic [7:0]  VOL_FULL      = 8'd255;

   // ID letters "S-MSU1" at window indexes 2..7
   function automatic logic [7:0] id_letter(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd2:    ch = 8'h53;
         3'd3:    ch = 8'h2d;
         3'd4:    ch = 8'h4d;
         3'd5:    ch = 8'h53;
         3'd6:    ch = 8'h55;
         3'd7:    ch = 8'h31;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: sv/streamed_audio_data_port_controller.sv
// Top level: register window, track/seek state and sample scaling of the media port.
//
//  channel | direction | handshake           | word
//  req_    | in        | req_valid/req_ready | bus read, bus write, sample tick, track report
//  rsp_    | out       | rsp_valid/rsp_ready | read data, offsets, strobes, scaled samples
//
// One word per cycle sustained while rsp_ready holds; each word passes the input register, then the result register.
// All state updates as a word moves from the input register into the result register.
// A stalled rsp_ holds the input register; req_ready stays high while it can still drain.
// Synchronous active-high reset clears the valid flags and block state; resume track resets to none.
module streamed_audio_data_port_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [2:0]            req_addr,
   input  logic [7:0]            req_byte_in,
   input  logic                  req_data_ready,
   input  logic                  req_audio_present,
   input  logic                  req_audio_end,
   input  sadpc_pkg::sample_type req_raw_left,
   input  sadpc_pkg::sample_type req_raw_right,
   input  logic                  req_mute,
   input  logic [31:0]           req_file_size,
   input  logic [31:0]           req_magic_word,
   input  logic [31:0]           req_loop_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_read_data,
   output logic [31:0]           rsp_data_address,
   output logic                  rsp_data_seek,
   output logic                  rsp_data_advance,
   output logic                  rsp_open_track,
   output logic [15:0]           rsp_track_number,
   output logic                  rsp_audio_seek,
   output logic [31:0]           rsp_audio_address,
   output logic                  rsp_sample_valid,
   output sadpc_pkg::sample_type rsp_left_out,
   output sadpc_pkg::sample_type rsp_right_out
);

   // input register
   logic                  s1_valid_ff, s1_valid_in;
   sadpc_pkg::op_type     op_ff;
   logic [2:0]            addr_ff;
   logic [7:0]            byte_ff;
   logic                  dready_ff, apresent_ff, aend_ff, mute_ff;
   sadpc_pkg::sample_type raw_left_ff, raw_right_ff;
   logic [31:0]           fsize_ff, magic_ff, loopw_ff;

   // block state
   logic [31:0] seek_offset_ff, seek_offset_in;
   logic [31:0] read_offset_ff, read_offset_in;
   logic [31:0] play_offset_ff, play_offset_in;
   logic [31:0] loop_offset_ff, loop_offset_in;
   logic [31:0] resume_offset_ff, resume_offset_in;
   logic [15:0] track_ff, track_in;
   logic [15:0] resume_track_ff, resume_track_in;
   logic [7:0]  volume_ff, volume_in;
   logic        error_ff, error_in;
   logic        play_ff, play_in;
   logic        repeat_ff, repeat_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rd_ff, rd_in;
   logic                  dseek_ff, dseek_in;
   logic                  dadv_ff, dadv_in;
   logic                  otrack_ff, otrack_in;
   logic                  aseek_ff, aseek_in;
   logic                  svalid_ff, svalid_in;
   sadpc_pkg::sample_type left_ff, left_in;
   sadpc_pkg::sample_type right_ff, right_in;

   logic                  req_fire, fire;
   sadpc_pkg::sample_type left_scaled, right_scaled;
   logic [31:0]           loop_calc;
   logic [15:0]           track_new_hi;

   assign fire      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || fire;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff        <= sadpc_pkg::op_type'(req_op);
         addr_ff      <= req_addr;
         byte_ff      <= req_byte_in;
         dready_ff    <= req_data_ready;
         apresent_ff  <= req_audio_present;
         aend_ff      <= req_audio_end;
         mute_ff      <= req_mute;
         raw_left_ff  <= req_raw_left;
         raw_right_ff <= req_raw_right;
         fsize_ff     <= req_file_size;
         magic_ff     <= req_magic_word;
         loopw_ff     <= req_loop_word;
      end
   end

   sadpc_scale u_scale_left (
      .raw    (raw_left_ff),
      .volume (volume_ff),
      .scaled (left_scaled)
   );

   sadpc_scale u_scale_right (
      .raw    (raw_right_ff),
      .volume (volume_ff),
      .scaled (right_scaled)
   );

   assign loop_calc    = sadpc_pkg::TRACK_START + (loopw_ff << 2);
   assign track_new_hi = {byte_ff, track_ff[7:0]};

   always_comb begin
      seek_offset_in   = seek_offset_ff;
      read_offset_in   = read_offset_ff;
      play_offset_in   = play_offset_ff;
      loop_offset_in   = loop_offset_ff;
      resume_offset_in = resume_offset_ff;
      track_in         = track_ff;
      resume_track_in  = resume_track_ff;
      volume_in        = volume_ff;
      error_in         = error_ff;
      play_in          = play_ff;
      repeat_in        = repeat_ff;
      rd_in            = 8'd0;
      dseek_in         = 1'b0;
      dadv_in          = 1'b0;
      otrack_in        = 1'b0;
      aseek_in         = 1'b0;
      svalid_in        = 1'b0;
      left_in          = '0;
      right_in         = '0;

      unique case (op_ff)
         sadpc_pkg::OP_READ: begin
            if (addr_ff == sadpc_pkg::REG_STATUS) begin
               rd_in = {2'b00, repeat_ff, play_ff, error_ff, sadpc_pkg::REVISION};
            end else if (addr_ff == sadpc_pkg::REG_DATA) begin
               if (dready_ff) begin
                  read_offset_in = read_offset_ff + 32'd1;
                  rd_in          = byte_ff;
                  dadv_in        = 1'b1;
               end
            end else begin
               rd_in = sadpc_pkg::id_letter(addr_ff);
            end
         end
         sadpc_pkg::OP_WRITE: begin
            unique case (addr_ff)
               sadpc_pkg::REG_SEEK0: seek_offset_in = {seek_offset_ff[31:8], byte_ff};
               sadpc_pkg::REG_SEEK1:
                  seek_offset_in = {seek_offset_ff[31:16], byte_ff, seek_offset_ff[7:0]};
               sadpc_pkg::REG_SEEK2:
                  seek_offset_in = {seek_offset_ff[31:24], byte_ff, seek_offset_ff[15:0]};
               sadpc_pkg::REG_SEEK3: begin
                  seek_offset_in = {byte_ff, seek_offset_ff[23:0]};
                  read_offset_in = {byte_ff, seek_offset_ff[23:0]};
                  dseek_in       = 1'b1;
               end
               sadpc_pkg::REG_TRACK_LO: track_in = {track_ff[15:8], byte_ff};
               sadpc_pkg::REG_TRACK_HI: begin
                  track_in  = track_new_hi;
                  play_in   = 1'b0;
                  repeat_in = 1'b0;
                  otrack_in = 1'b1;
                  if (track_new_hi == resume_track_ff) begin
                     play_offset_in   = resume_offset_ff;
                     resume_track_in  = sadpc_pkg::NO_RESUME;
                     resume_offset_in = 32'd0;
                  end else begin
                     play_offset_in = sadpc_pkg::TRACK_START;
                  end
               end
               sadpc_pkg::REG_VOLUME: volume_in = byte_ff;
               sadpc_pkg::REG_CONTROL: begin
                  // ignored while the last report flagged an error
                  if (!error_ff) begin
                     play_in   = byte_ff[0];
                     repeat_in = byte_ff[1];
                     if (!byte_ff[0] && byte_ff[2]) begin
                        resume_track_in  = track_ff;
                        resume_offset_in = play_offset_ff;
                     end
                  end
               end
               default: ;
            endcase
         end
         sadpc_pkg::OP_TICK: begin
            svalid_in = 1'b1;
            if (play_ff) begin
               if (!apresent_ff) begin
                  play_in = 1'b0;
               end else if (aend_ff) begin
                  aseek_in = 1'b1;
                  if (!repeat_ff) begin
                     play_in        = 1'b0;
                     play_offset_in = sadpc_pkg::TRACK_START;
                  end else begin
                     play_offset_in = loop_offset_ff;
                  end
               end else begin
                  play_offset_in = play_offset_ff + sadpc_pkg::SAMPLE_BYTES;
                  if (!mute_ff) begin
                     left_in  = left_scaled;
                     right_in = right_scaled;
                  end
               end
            end
         end
         sadpc_pkg::OP_REPORT: begin
            if (apresent_ff && (fsize_ff >= sadpc_pkg::TRACK_START)
                && (magic_ff == sadpc_pkg::HDR_MAGIC)) begin
               // loop point past the end of file falls back to the track start
               loop_offset_in = (loop_calc > fsize_ff) ? sadpc_pkg::TRACK_START : loop_calc;
               error_in       = 1'b0;
               aseek_in       = 1'b1;
            end else begin
               error_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seek_offset_ff   <= 32'd0;
         read_offset_ff   <= 32'd0;
         play_offset_ff   <= 32'd0;
         loop_offset_ff   <= 32'd0;
         resume_offset_ff <= 32'd0;
         track_ff         <= 16'd0;
         resume_track_ff  <= sadpc_pkg::NO_RESUME;
         volume_ff        <= 8'd0;
         error_ff         <= 1'b0;
         play_ff          <= 1'b0;
         repeat_ff        <= 1'b0;
      end else if (fire) begin
         seek_offset_ff   <= seek_offset_in;
         read_offset_ff   <= read_offset_in;
         play_offset_ff   <= play_offset_in;
         loop_offset_ff   <= loop_offset_in;
         resume_offset_ff <= resume_offset_in;
         track_ff         <= track_in;
         resume_track_ff  <= resume_track_in;
         volume_ff        <= volume_in;
         error_ff         <= error_in;
         play_ff          <= play_in;
         repeat_ff        <= repeat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rd_ff     <= rd_in;
         dseek_ff  <= dseek_in;
         dadv_ff   <= dadv_in;
         otrack_ff <= otrack_in;
         aseek_ff  <= aseek_in;
         svalid_ff <= svalid_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
      end
   end

   // offsets and track are read straight from state, which only moves with the result
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rd_ff;
   assign rsp_data_address  = read_offset_ff;
   assign rsp_data_seek     = dseek_ff;
   assign rsp_data_advance  = dadv_ff;
   assign rsp_open_track    = otrack_ff;
   assign rsp_track_number  = track_ff;
   assign rsp_audio_seek    = aseek_ff;
   assign rsp_audio_address = play_offset_ff;
   assign rsp_sample_valid  = svalid_ff;
   assign rsp_left_out      = left_ff;
   assign rsp_right_out     = right_ff;

   a_tick_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && svalid_ff |-> rd_ff == 8'd0 && !dseek_ff && !dadv_ff && !otrack_ff)
      else $error("tick word carries bus-side strobes");

   a_read_advance : assert property (@(posedge clock) disable iff (reset)
      fire && op_ff == sadpc_pkg::OP_READ && addr_ff == sadpc_pkg::REG_DATA && dready_ff
      |=> read_offset_ff == $past(read_offset_ff) + 32'd1)
      else $error("data read did not advance the read offset");

   a_idle_silent : assert property (@(posedge clock) disable iff (reset)
      fire && op_ff == sadpc_pkg::OP_TICK && !play_ff
      |=> left_ff == '0 && right_ff == '0 && play_offset_ff == $past(play_offset_ff))
      else $error("idle tick produced audio or moved the play offset");

   a_hold_stage : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !fire |=> s1_valid_ff)
      else $error("input register dropped a word under stall");

endmodule

FILE: sv/sadpc_scale.sv
// Volume scaler: sample * volume / 255, truncated toward zero.
module sadpc_scale (
   input  sadpc_pkg::sample_type raw,
   input  logic [7:0]            volume,
   output sadpc_pkg::sample_type scaled
);

   logic        neg;
   logic [16:0] raw_ext;
   logic [16:0] mag;
   logic [24:0] prod;
   logic [24:0] prod_p1;
   logic [25:0] est_sum;
   logic [17:0] q_est;
   logic [26:0] q_times;
   logic signed [26:0] rem;
   logic [17:0] q;

   assign neg     = raw[15];
   assign raw_ext = {raw[15], raw};
   assign mag     = neg ? (17'd0 - raw_ext) : raw_ext;
   assign prod    = 25'(mag) * 25'(volume);

   // divide by 255 via x/256 * (1 + 1/256 + 1/65536), then one-step fixup
   assign prod_p1 = prod + 25'd1;
   assign est_sum = 26'(prod_p1) + 26'(prod_p1 >> 8) + 26'(prod_p1 >> 16);
   assign q_est   = est_sum[25:8];
   assign q_times = (27'(q_est) << 8) - 27'(q_est);
   assign rem     = $signed(27'(prod)) - $signed(q_times);

   always_comb begin
      if (rem < 0) begin
         q = q_est - 18'd1;
      end else if (rem >= $signed(27'(sadpc_pkg::VOL_FULL))) begin
         q = q_est + 18'd1;
      end else begin
         q = q_est;
      end
   end

   assign scaled = neg ? sadpc_pkg::sample_type'(16'd0 - q[15:0])
                       : sadpc_pkg::sample_type'(q[15:0]);

endmodule
